// ----- src/rrs_pkg.sv -----
package rrs_pkg;

	localparam int unsigned MaxTasks = 8;
	localparam int unsigned TidW     = 3;
	localparam int unsigned CntW     = 4;

	localparam logic [2:0] OpStart  = 3'd0;
	localparam logic [2:0] OpTick   = 3'd1;
	localparam logic [2:0] OpIoDone = 3'd2;
	localparam logic [2:0] OpIoReq  = 3'd3;
	localparam logic [2:0] OpFinish = 3'd4;

	// Slot 0 is always the head of the queue.
	typedef struct packed {
		logic [MaxTasks-1:0][TidW-1:0] slot;
		logic [CntW-1:0]               cnt;
	} queue_t;

	typedef struct packed {
		logic            hit;
		logic [TidW-1:0] tid;
	} pick_t;

endpackage

// ----- src/rrs_pick.sv -----
module rrs_pick (
	input  rrs_pkg::queue_t                  q_in,
	input  logic [rrs_pkg::MaxTasks-1:0]     fin,
	output rrs_pkg::pick_t                   pick,
	output rrs_pkg::queue_t                  q_out
);

	logic [rrs_pkg::MaxTasks-1:0] elig;
	logic [rrs_pkg::TidW-1:0]     idx;
	logic [rrs_pkg::CntW-1:0]     amt;

	// Entries ahead of the first unfinished task are dropped along with it.
	always_comb begin
		for (int k = 0; k < rrs_pkg::MaxTasks; k++) begin
			elig[k] = (rrs_pkg::CntW'(k) < q_in.cnt) && !fin[q_in.slot[k]];
		end
		idx = '0;
		for (int k = rrs_pkg::MaxTasks - 1; k >= 0; k--) begin
			if (elig[k]) begin
				idx = rrs_pkg::TidW'(k);
			end
		end
		pick.hit = |elig;
		pick.tid = q_in.slot[idx];
		amt = {1'b0, idx} + rrs_pkg::CntW'(1);
		q_out.slot = q_in.slot >> (6'(amt) * 6'(rrs_pkg::TidW));
		q_out.cnt = pick.hit ? (q_in.cnt - amt) : '0;
	end

endmodule

// ----- src/round_robin_task_scheduler.sv -----
// Each accepted event word produces exactly one result word, with done high
// in the cycle after the accepting edge.
// A new event is taken on every clock, so busy never rises.
// Asynchronous reset leaves the CPU idle, no task scheduled, both queues
// empty, counters at zero and the task count register at three.
// The receiver cannot stall, so results are never held back.
module round_robin_task_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [2:0]  task_id,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	output logic        done,
	output logic [2:0]  running_task,
	output logic        cpu_busy,
	output logic        dispatched,
	output logic        preempted,
	output logic [15:0] preempt_count,
	output logic [3:0]  ready_count,
	output logic [3:0]  wait_count,
	output logic        all_done
);

	rrs_pkg::queue_t              rq_q, wq_q, rq_mid, wq_mid, rq_n, pick_q;
	rrs_pkg::pick_t               pick;
	logic [rrs_pkg::MaxTasks-1:0] fin_q, fin_mid;
	logic [rrs_pkg::TidW-1:0]     cur_q, cur_mid, cur_n;
	logic                         valid_q, valid_mid, valid_n;
	logic [15:0]                  pcnt_q, pcnt_n;
	logic [3:0]                   fcnt_q, fcnt_n;
	logic [3:0]                   sched_q, sched_n;
	logic [3:0]                   tcount_q;
	logic [3:0]                   n_start;
	logic                         disp_q, disp_a, disp_n;
	logic                         pre_q, pre_n;
	logic                         done_q;
	logic                         do_disp;
	logic                         rpush;
	logic [rrs_pkg::TidW-1:0]     rpush_tid;
	logic [rrs_pkg::TidW-1:0]     wtid;
	logic                         tid_ok;
	logic                         accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign tid_ok = {1'b0, task_id} < sched_q;

	always_comb begin
		if (tcount_q == 4'd0) begin
			n_start = 4'd1;
		end else if (tcount_q > 4'(rrs_pkg::MaxTasks)) begin
			n_start = 4'(rrs_pkg::MaxTasks);
		end else begin
			n_start = tcount_q;
		end
	end

	always_comb begin
		rq_mid    = rq_q;
		wq_mid    = wq_q;
		fin_mid   = fin_q;
		cur_mid   = cur_q;
		valid_mid = valid_q;
		pcnt_n    = pcnt_q;
		fcnt_n    = fcnt_q;
		sched_n   = sched_q;
		disp_a    = 1'b0;
		pre_n     = 1'b0;
		do_disp   = 1'b0;
		rpush     = 1'b0;
		rpush_tid = '0;
		wtid      = wq_q.slot[0];
		case (operation)
			rrs_pkg::OpStart: begin
				for (int k = 0; k < rrs_pkg::MaxTasks; k++) begin
					rq_mid.slot[k] = rrs_pkg::TidW'(k + 1);
				end
				rq_mid.cnt = n_start - 4'd1;
				wq_mid.cnt = '0;
				fin_mid    = '0;
				cur_mid    = '0;
				valid_mid  = 1'b1;
				fcnt_n     = '0;
				sched_n    = n_start;
				disp_a     = 1'b1;
			end
			rrs_pkg::OpTick: begin
				if (valid_q) begin
					pre_n     = 1'b1;
					pcnt_n    = pcnt_q + 16'd1;
					rpush     = !fin_q[cur_q];
					rpush_tid = cur_q;
					valid_mid = 1'b0;
					cur_mid   = '0;
					do_disp   = 1'b1;
				end
			end
			rrs_pkg::OpIoDone: begin
				if (wq_q.cnt != 4'd0) begin
					wq_mid.slot = wq_q.slot >> rrs_pkg::TidW;
					wq_mid.cnt  = wq_q.cnt - 4'd1;
					if (!fin_q[wtid]) begin
						rpush     = 1'b1;
						rpush_tid = wtid;
						do_disp   = !valid_q;
					end
				end
			end
			rrs_pkg::OpIoReq: begin
				if (tid_ok && valid_q && cur_q == task_id && !fin_q[task_id]) begin
					if (wq_q.cnt < 4'(rrs_pkg::MaxTasks)) begin
						wq_mid.slot[wq_q.cnt[rrs_pkg::TidW-1:0]] = task_id;
						wq_mid.cnt = wq_q.cnt + 4'd1;
					end
					valid_mid = 1'b0;
					cur_mid   = '0;
					do_disp   = 1'b1;
				end
			end
			rrs_pkg::OpFinish: begin
				if (tid_ok && !fin_q[task_id]) begin
					fin_mid[task_id] = 1'b1;
					fcnt_n = fcnt_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
		if (rpush && rq_q.cnt < 4'(rrs_pkg::MaxTasks)) begin
			rq_mid.slot[rq_q.cnt[rrs_pkg::TidW-1:0]] = rpush_tid;
			rq_mid.cnt = rq_q.cnt + 4'd1;
		end
	end

	rrs_pick u_pick (
		.q_in  (rq_mid),
		.fin   (fin_mid),
		.pick  (pick),
		.q_out (pick_q)
	);

	always_comb begin
		rq_n    = rq_mid;
		cur_n   = cur_mid;
		valid_n = valid_mid;
		disp_n  = disp_a;
		if (do_disp) begin
			rq_n = pick_q;
			if (pick.hit) begin
				cur_n   = pick.tid;
				valid_n = 1'b1;
				disp_n  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= 4'd3;
		end else if (cfg_we) begin
			tcount_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_q     <= '0;
			wq_q     <= '0;
			fin_q    <= '0;
			cur_q    <= '0;
			valid_q  <= 1'b0;
			pcnt_q   <= '0;
			fcnt_q   <= '0;
			sched_q  <= '0;
			disp_q   <= 1'b0;
			pre_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				rq_q     <= rq_n;
				wq_q     <= wq_mid;
				fin_q    <= fin_mid;
				cur_q    <= cur_n;
				valid_q  <= valid_n;
				pcnt_q   <= pcnt_n;
				fcnt_q   <= fcnt_n;
				sched_q  <= sched_n;
				disp_q   <= disp_n;
				pre_q    <= pre_n;
			end
		end
	end

	assign done          = done_q;
	assign running_task  = valid_q ? cur_q : '0;
	assign cpu_busy      = valid_q;
	assign dispatched    = disp_q;
	assign preempted     = pre_q;
	assign preempt_count = pcnt_q;
	assign ready_count   = rq_q.cnt;
	assign wait_count    = wq_q.cnt;
	assign all_done      = (sched_q != 4'd0) && (fcnt_q == sched_q);

`ifndef SYNTHESIS
	a_task_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(5'(rq_q.cnt) + 5'(wq_q.cnt) + 5'(valid_q)) <= 5'(sched_q))
		else $error("More tasks queued or running than scheduled.");

	a_disp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && disp_q |-> valid_q)
		else $error("Dispatch reported with an idle CPU.");

	a_preempt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && pre_q |-> pcnt_q == 16'($past(pcnt_q) + 16'd1))
		else $error("Preemption count did not advance on a preemption.");

	a_idle_task: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> cur_q == '0)
		else $error("Current task is nonzero while the CPU is idle.");
`endif

endmodule
